>>> design/dllm_pkg.sv
// Package: opcodes, status codes, channel payloads and controller states for the list manager.
package dllm_pkg;

    typedef enum logic [2:0] {
        OP_ADD_HEAD = 3'd0,
        OP_ADD_TAIL = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_REM_HEAD = 3'd3,
        OP_REM_TAIL = 3'd4,
        OP_CLEAR    = 3'd5,
        OP_NOP6     = 3'd6,
        OP_NOP7     = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_LINKED = 2'd1,
        ST_NOT_IN = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] list_id;
        logic [7:0] node_id;
        logic       ignore_owner;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] result_node;
        logic [8:0] list_count;
        logic       node_detached;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_DECIDE,
        S_DET1,
        S_DET2,
        S_ADD1,
        S_ADD2,
        S_FETCH,
        S_DONE
    } state_t;

endpackage

>>> design/dllm_chan_if.sv
// Valid/ready channel interface carrying one payload of type T.
interface dllm_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/dllm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dllm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/doubly_linked_list_manager.sv
// Top level: doubly linked list manager over a node pool held in link memories.
//
//   channel | dir | payload                                          | handshake
//   req     | in  | opcode, list_id, node_id, ignore_owner           | valid/ready
//   rsp     | out | status, result_node, list_count, node_detached   | valid/ready
//
// An operation runs ADDR, DECIDE, DET1/DET2 or ADD1/ADD2, FETCH and DONE; a refused or
// empty one goes from DECIDE to FETCH, and clear repeats ADDR, DECIDE, DET1, DET2 per
// node. Each step is one access of the node memories (registered read), with a final
// read for the detached mark. After reset a clearing pass initializes the node memories;
// req.ready stays low meanwhile. req.ready is high only between operations; a result
// waits in the rsp register, and the next operation stalls only at its own result.
module doubly_linked_list_manager
    import dllm_pkg::*;
#(
    parameter int NUM_NODES = 256,
    parameter int NUM_LISTS = 4
) (
    input  logic   clk,
    input  logic   rst_n,
    dllm_chan_if.sink   req,
    dllm_chan_if.source rsp
);
    localparam int PW  = $clog2(NUM_NODES + 1);
    localparam int NW  = $clog2(NUM_NODES);
    localparam int LSW = ($clog2(NUM_LISTS + 1) > 2) ? $clog2(NUM_LISTS + 1) : 2;
    localparam int LW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [PW-1:0]  NODE_NULL  = PW'(NUM_NODES);
    localparam logic [LSW-1:0] OWNER_NONE = LSW'(NUM_LISTS);
    localparam logic [NW-1:0]  LAST_NODE  = NW'(NUM_NODES - 1);

    state_t state_reg, state_next;

    logic [NW-1:0]  clr_reg, clr_next;
    logic [2:0]     op_reg, op_next;
    logic [7:0]     n_reg, n_next;
    logic           ign_reg, ign_next;
    logic [LSW-1:0] cur_reg, cur_next;
    logic [PW-1:0]  tgt_reg, tgt_next;
    logic [PW-1:0]  p_reg, p_next;
    logic [PW-1:0]  q_reg, q_next;
    logic [PW-1:0]  a_reg, a_next;
    logic [PW-1:0]  fet_reg, fet_next;
    logic [1:0]     status_reg, status_next;
    logic [7:0]     res_reg, res_next;

    logic [PW-1:0] head_reg [NUM_LISTS];
    logic [PW-1:0] head_next [NUM_LISTS];
    logic [PW-1:0] tail_reg [NUM_LISTS];
    logic [PW-1:0] tail_next [NUM_LISTS];
    logic [PW-1:0] count_reg [NUM_LISTS];
    logic [PW-1:0] count_next [NUM_LISTS];

    logic  out_valid_reg, out_valid_next;
    rsp_t  out_data_reg, out_data_next;

    // node memory ports
    logic [NW-1:0]  rd_addr;
    logic           prev_we, next_we, own_we, det_we;
    logic [NW-1:0]  prev_wa, next_wa, own_wa, det_wa;
    logic [PW-1:0]  prev_wd, next_wd, prev_rd, next_rd;
    logic [LSW-1:0] own_wd, own_rd;
    logic           det_wd, det_rd;

    logic [LW-1:0] ci;
    logic          cur_ok, n_ok, tgt_ok, a_ok, p_ok, q_ok, fet_ok, out_free;

    dllm_ram #(.WIDTH(PW), .DEPTH(NUM_NODES)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(rd_addr), .rdata(prev_rd)
    );
    dllm_ram #(.WIDTH(PW), .DEPTH(NUM_NODES)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(rd_addr), .rdata(next_rd)
    );
    dllm_ram #(.WIDTH(LSW), .DEPTH(NUM_NODES)) u_own_ram (
        .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
        .raddr(rd_addr), .rdata(own_rd)
    );
    dllm_ram #(.WIDTH(1), .DEPTH(NUM_NODES)) u_det_ram (
        .clk(clk), .we(det_we), .waddr(det_wa), .wdata(det_wd),
        .raddr(rd_addr), .rdata(det_rd)
    );

    assign ci       = cur_reg[LW-1:0];
    assign cur_ok   = cur_reg < LSW'(NUM_LISTS);
    assign n_ok     = 32'(n_reg) < NUM_NODES;
    assign tgt_ok   = tgt_reg < NODE_NULL;
    assign a_ok     = a_reg < NODE_NULL;
    assign p_ok     = p_reg < NODE_NULL;
    assign q_ok     = q_reg < NODE_NULL;
    assign fet_ok   = fet_reg < NODE_NULL;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (clr_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_FETCH;
                if (op_reg == OP_REMOVE && ign_reg)
                begin
                    if (tgt_ok && own_rd < OWNER_NONE)
                    begin
                        state_next = S_DET1;
                    end
                end
                else if (op_reg <= OP_CLEAR && !cur_ok)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    unique case (op_reg)
                        OP_ADD_HEAD, OP_ADD_TAIL:
                        begin
                            if (tgt_ok && !(own_rd < OWNER_NONE))
                            begin
                                state_next = S_ADD1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (tgt_ok && own_rd == cur_reg)
                            begin
                                state_next = S_DET1;
                            end
                        end
                        OP_REM_HEAD, OP_REM_TAIL, OP_CLEAR:
                        begin
                            if (tgt_ok)
                            begin
                                state_next = S_DET1;
                            end
                        end
                        default:
                        begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_DET1:
            begin
                state_next = S_DET2;
            end
            S_DET2:
            begin
                state_next = (op_reg == OP_CLEAR) ? S_ADDR : S_FETCH;
            end
            S_ADD1:
            begin
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory writes
    always_comb
    begin
        clr_next       = clr_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        ign_next       = ign_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        a_next         = a_reg;
        fet_next       = fet_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        rd_addr = tgt_reg[NW-1:0];
        prev_we = 1'b0;
        next_we = 1'b0;
        own_we  = 1'b0;
        det_we  = 1'b0;
        prev_wa = tgt_reg[NW-1:0];
        next_wa = tgt_reg[NW-1:0];
        own_wa  = tgt_reg[NW-1:0];
        det_wa  = tgt_reg[NW-1:0];
        prev_wd = NODE_NULL;
        next_wd = NODE_NULL;
        own_wd  = OWNER_NONE;
        det_wd  = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                prev_we  = 1'b1;
                next_we  = 1'b1;
                own_we   = 1'b1;
                det_we   = 1'b1;
                prev_wa  = clr_reg;
                next_wa  = clr_reg;
                own_wa   = clr_reg;
                det_wa   = clr_reg;
                clr_next = clr_reg + NW'(1);
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.data.opcode;
                    n_next   = req.data.node_id;
                    ign_next = req.data.ignore_owner;
                    cur_next = LSW'(req.data.list_id);
                end
            end
            S_ADDR:
            begin
                // clear walks from the head each pass
                unique case (op_reg)
                    OP_REM_HEAD, OP_CLEAR:
                        tgt_next = cur_ok ? head_reg[ci] : NODE_NULL;
                    OP_REM_TAIL:
                        tgt_next = cur_ok ? tail_reg[ci] : NODE_NULL;
                    default:
                        tgt_next = n_ok ? PW'(n_reg) : NODE_NULL;
                endcase
                rd_addr = tgt_next[NW-1:0];
            end
            S_DECIDE:
            begin
                p_next      = prev_rd;
                q_next      = next_rd;
                status_next = ST_DONE;
                res_next    = n_reg;
                fet_next    = n_ok ? PW'(n_reg) : NODE_NULL;
                if (op_reg == OP_REMOVE && ign_reg)
                begin
                    if (tgt_ok && own_rd < OWNER_NONE)
                    begin
                        cur_next = own_rd;
                    end
                    else
                    begin
                        status_next = ST_NOT_IN;
                    end
                end
                else if (op_reg <= OP_CLEAR && !cur_ok)
                begin
                    status_next = ST_NOT_IN;
                end
                else
                begin
                    unique case (op_reg)
                        OP_ADD_HEAD, OP_ADD_TAIL:
                        begin
                            a_next = (op_reg == OP_ADD_HEAD) ? head_reg[ci] : tail_reg[ci];
                            if (!tgt_ok)
                            begin
                                status_next = ST_NOT_IN;
                            end
                            else if (own_rd < OWNER_NONE)
                            begin
                                status_next = ST_LINKED;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!tgt_ok || own_rd != cur_reg)
                            begin
                                status_next = ST_NOT_IN;
                            end
                        end
                        OP_REM_HEAD, OP_REM_TAIL:
                        begin
                            if (!tgt_ok)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_next = 8'(tgt_reg);
                                fet_next = tgt_reg;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_DET1:
            begin
                if (p_ok)
                begin
                    next_we = 1'b1;
                    next_wa = p_reg[NW-1:0];
                    next_wd = q_reg;
                end
                else
                begin
                    head_next[ci] = q_reg;
                end
                if (q_ok)
                begin
                    prev_we = 1'b1;
                    prev_wa = q_reg[NW-1:0];
                    prev_wd = p_reg;
                end
                else
                begin
                    tail_next[ci] = p_reg;
                end
                own_we = 1'b1;
                det_we = 1'b1;
                det_wd = 1'b1;
                if (count_reg[ci] != '0)
                begin
                    count_next[ci] = count_reg[ci] - PW'(1);
                end
            end
            S_DET2:
            begin
                prev_we = 1'b1;
                next_we = 1'b1;
            end
            S_ADD1:
            begin
                own_we         = 1'b1;
                own_wd         = cur_reg;
                det_we         = 1'b1;
                prev_we        = 1'b1;
                next_we        = 1'b1;
                count_next[ci] = count_reg[ci] + PW'(1);
                if (op_reg == OP_ADD_HEAD)
                begin
                    next_wd       = a_reg;
                    head_next[ci] = tgt_reg;
                    if (!a_ok)
                    begin
                        tail_next[ci] = tgt_reg;
                    end
                end
                else
                begin
                    prev_wd       = a_reg;
                    tail_next[ci] = tgt_reg;
                    if (!a_ok)
                    begin
                        head_next[ci] = tgt_reg;
                    end
                end
            end
            S_ADD2:
            begin
                if (a_ok)
                begin
                    if (op_reg == OP_ADD_HEAD)
                    begin
                        prev_we = 1'b1;
                        prev_wa = a_reg[NW-1:0];
                        prev_wd = tgt_reg;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = a_reg[NW-1:0];
                        next_wd = tgt_reg;
                    end
                end
            end
            S_FETCH:
            begin
                rd_addr = fet_reg[NW-1:0];
            end
            S_DONE:
            begin
                // keep the detached-mark read on the result node while stalled
                rd_addr = fet_reg[NW-1:0];
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.result_node   = res_reg;
                    out_data_next.list_count    = cur_ok ? 9'(count_reg[ci]) : 9'd0;
                    out_data_next.node_detached = fet_ok ? det_rd : 1'b0;
                end
            end
            default:
            begin
                rd_addr = tgt_reg[NW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i]  <= NODE_NULL;
                tail_reg[i]  <= NODE_NULL;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        n_reg        <= n_next;
        ign_reg      <= ign_next;
        cur_reg      <= cur_next;
        tgt_reg      <= tgt_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        a_reg        <= a_next;
        fet_reg      <= fet_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // a node reported as already linked was never detached since its add
    a_linked_not_detached: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == ST_LINKED) |-> !rsp.data.node_detached)
        else $error("linked node reported as detached");

    a_accept_goes_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_ADDR))
        else $error("transfer not followed by address phase");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (rsp.valid && state_reg == S_IDLE))
        else $error("result not loaded");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg[0]) <= NUM_NODES)
        else $error("list count exceeds pool");

    a_unlink_keeps_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DET1) |-> cur_ok)
        else $error("detach on invalid list");
`endif

endmodule
